### hdl/drp_pkg.sv
package drp_pkg;

   // Largest ring supported by the descriptor table
   localparam int MAX_RING = 256;
   localparam int MaxRingLog2 = $clog2(MAX_RING + 1) - 1;
   localparam int RingLog2Cap = (MaxRingLog2 < 8) ? MaxRingLog2 : 8;

   // Result queue depth and its pointer width
   localparam int RspFifoDepth = 8;
   localparam int RspPtrWidth = $clog2(RspFifoDepth);

   // Descriptor flag bits
   localparam int DESC_FLAG_NEXT = 0;
   localparam int DESC_FLAG_WRITE = 1;

   // Configuration register indexes
   localparam logic REG_RING_SIZE_LOG2 = 1'b0;
   localparam logic REG_QUEUE_NUMBER = 1'b1;

   typedef enum logic [1:0] {
      KIND_DESC     = 2'd0,
      KIND_PUBLISH  = 2'd1,
      KIND_COMPLETE = 2'd2,
      KIND_REJECT   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type     kind;
      logic [7:0]   slot_index;
      logic [63:0]  desc_address;
      logic [31:0]  desc_length;
      logic [1:0]   desc_flags;
      logic [7:0]   next_index;
      logic [7:0]   head_index;
      logic [15:0]  available_count;
      logic [15:0]  tag;
      logic [15:0]  notify_queue;
      logic         last;
   } rsp_type;

   // Clamp the programmed log2 size to what the ring supports
   function automatic logic [3:0] ring_log2_eff(input logic [3:0] lg);
      logic [3:0] res;
      res = lg;
      if (lg > 4'(RingLog2Cap)) begin
         res = 4'(RingLog2Cap);
      end
      return res;
   endfunction

endpackage

### hdl/drp_rsp_fifo.sv
module drp_rsp_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [1:0]                 push_n,
   input  drp_pkg::rsp_type           push0,
   input  drp_pkg::rsp_type           push1,
   input  logic                       pop,
   output drp_pkg::rsp_type           head,
   output logic [drp_pkg::RspPtrWidth:0] count
);
   import drp_pkg::*;

   rsp_type                 mem_ff [RspFifoDepth];
   logic [RspPtrWidth-1:0]  wr_ptr_ff;
   logic [RspPtrWidth-1:0]  rd_ptr_ff;
   logic [RspPtrWidth:0]    count_ff;
   logic [RspPtrWidth:0]    count_in;
   logic                    pop_ok;

   assign pop_ok = pop && (count_ff != '0);
   assign count_in = count_ff + (RspPtrWidth + 1)'(push_n) - (RspPtrWidth + 1)'(pop_ok);
   assign head = mem_ff[rd_ptr_ff];
   assign count = count_ff;

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + RspPtrWidth'(push_n);
         rd_ptr_ff <= rd_ptr_ff + RspPtrWidth'(pop_ok);
         count_ff <= count_in;
      end
   end

   // Store up to two results per cycle
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ptr_ff + RspPtrWidth'(1)] <= push1;
      end
   end

endmodule

### hdl/descriptor_ring_producer.sv
// Driver side of a split descriptor ring.
// req_ channel: one segment or used element per transfer. A chain's first
//   segment carries its length and completion tag; later segments only
//   carry their buffer. A used element returns the stored tag of its head.
// rsp_ channel: descriptor writes, available-ring publishes with notify,
//   completions and chain rejects; tlast marks the final result of an item.
// csr_ port: register 0 is the log2 ring size, register 1 the queue number.
//   Writing the ring size restarts the free count and closes any open chain.
// Results are registered in a result stage, then queued for rsp_.
// Throughput: one item per cycle while req_tready is high, one result per
//   cycle on rsp_ while rsp_tready is high; the last segment of a chain
//   yields two results, so the 8-entry result queue and the result port
//   set the sustained rate. When the receiver stalls, results wait in the
//   queue; req_tready drops while fewer than two entries stay free beyond
//   those in flight. Reset: no chain open, full free count, ring size 256,
//   queue 0. The tag memory is not cleared; the user, not the block, must
//   ensure that only chain heads that were written are looked up.
module descriptor_ring_producer (
   input  logic          clock,
   input  logic          reset,
   // action
   input  logic          req_tuser,
   // buffer_address, buffer_length, device_writes, segment_total,
   // completion_tag, used_id, used_length, zero pad
   input  logic [167:0]  req_tdata,
   input  logic          req_tvalid,
   output logic          req_tready,
   // kind
   output logic [1:0]    rsp_tuser,
   // slot_index, desc_address, desc_length, desc_flags, next_index,
   // head_index, available_count, tag, notify_queue, zero pad
   output logic [175:0]  rsp_tdata,
   output logic          rsp_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic          csr_we,
   input  logic          csr_addr,
   input  logic [15:0]   csr_wdata
);
   import drp_pkg::*;

   // Request fields
   logic [63:0]  req_buffer_address;
   logic [31:0]  req_buffer_length;
   logic         req_device_writes;
   logic [8:0]   req_segment_total;
   logic [15:0]  req_completion_tag;
   logic [7:0]   req_used_id;
   logic [31:0]  req_used_length;

   assign req_buffer_address = req_tdata[63:0];
   assign req_buffer_length = req_tdata[95:64];
   assign req_device_writes = req_tdata[96];
   assign req_segment_total = req_tdata[105:97];
   assign req_completion_tag = req_tdata[121:106];
   assign req_used_id = req_tdata[129:122];
   assign req_used_length = req_tdata[161:130];

   // State
   logic [3:0]   ring_log2_ff, ring_log2_in;
   logic [15:0]  queue_ff, queue_in;
   logic [7:0]   next_free_ff, next_free_in;
   logic [8:0]   free_ff, free_in;
   logic [15:0]  avail_ff, avail_in;
   logic [8:0]   left_ff, left_in;
   logic [7:0]   head_ff, head_in;
   logic [15:0]  chain_tag_ff, chain_tag_in;
   logic         dropping_ff, dropping_in;

   // Result stage
   logic [1:0]   s1_n_ff, s1_n_in;
   logic         s1_cmp_ff, s1_cmp_in;
   rsp_type      s1_r0_ff, s1_r0_in;
   rsp_type      s1_r1_ff, s1_r1_in;
   rsp_type      push0;

   // Tag memory
   logic [15:0]  tag_mem [256];
   logic [15:0]  tag_rd_ff;
   logic         mem_we;
   logic [7:0]   mem_waddr;

   logic         req_fire;
   logic [3:0]   lg;
   logic [8:0]   ring_size;
   logic [7:0]   mask;
   logic [8:0]   total;
   logic [8:0]   left_cur;
   logic [8:0]   left_nx;
   logic [7:0]   head_cur;
   logic [15:0]  tag_cur;
   logic [7:0]   slot;
   logic [7:0]   nxt;
   logic         go;

   rsp_type               fifo_head;
   logic [RspPtrWidth:0]  fifo_count;

   assign req_fire = req_tvalid && req_tready;
   assign lg = ring_log2_eff(ring_log2_ff);
   assign ring_size = 9'd1 << lg;
   assign mask = 8'(ring_size - 9'd1);

   // Take an item only while the queue can hold everything in flight
   assign req_tready = (5'(fifo_count) + 5'(s1_n_ff)) <= 5'(RspFifoDepth - 2);

   // Configuration writes and per-item state update
   always_comb begin
      ring_log2_in = ring_log2_ff;
      queue_in = queue_ff;
      next_free_in = next_free_ff;
      free_in = free_ff;
      avail_in = avail_ff;
      left_in = left_ff;
      head_in = head_ff;
      chain_tag_in = chain_tag_ff;
      dropping_in = dropping_ff;
      s1_n_in = 2'd0;
      s1_cmp_in = 1'b0;
      s1_r0_in = '0;
      s1_r1_in = '0;
      mem_we = 1'b0;
      mem_waddr = next_free_ff & mask;
      total = (req_segment_total == 9'd0) ? 9'd1 : req_segment_total;
      left_cur = left_ff;
      left_nx = '0;
      head_cur = head_ff;
      tag_cur = chain_tag_ff;
      slot = next_free_ff & mask;
      nxt = (slot + 8'd1) & mask;
      go = 1'b0;
      if (csr_we) begin
         case (csr_addr)
            REG_RING_SIZE_LOG2: begin
               ring_log2_in = csr_wdata[3:0];
               free_in = 9'd1 << ring_log2_eff(csr_wdata[3:0]);
               next_free_in = '0;
               left_in = '0;
               dropping_in = 1'b0;
            end
            REG_QUEUE_NUMBER: begin
               queue_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end else if (req_fire) begin
         if (req_tuser) begin
            // Used element: tag is filled in from memory next cycle
            s1_r0_in.kind = KIND_COMPLETE;
            s1_r0_in.slot_index = req_used_id;
            s1_r0_in.desc_length = req_used_length;
            s1_r0_in.last = 1'b1;
            s1_n_in = 2'd1;
            s1_cmp_in = 1'b1;
         end else begin
            if (left_ff == 9'd0) begin
               if (free_ff < total) begin
                  // Reject the chain and drop its later segments
                  s1_r0_in.kind = KIND_REJECT;
                  s1_r0_in.tag = req_completion_tag;
                  s1_r0_in.last = 1'b1;
                  s1_n_in = 2'd1;
                  left_in = total - 9'd1;
                  dropping_in = (total != 9'd1);
               end else begin
                  free_in = free_ff - total;
                  head_cur = next_free_ff & mask;
                  tag_cur = req_completion_tag;
                  mem_we = 1'b1;
                  left_cur = total;
                  dropping_in = 1'b0;
                  go = 1'b1;
               end
            end else if (dropping_ff) begin
               left_in = left_ff - 9'd1;
               dropping_in = (left_ff != 9'd1);
            end else begin
               go = 1'b1;
            end
            if (go) begin
               // Write one descriptor, publish on the chain's last segment
               left_nx = left_cur - 9'd1;
               left_in = left_nx;
               head_in = head_cur;
               chain_tag_in = tag_cur;
               next_free_in = nxt;
               s1_r0_in.kind = KIND_DESC;
               s1_r0_in.slot_index = slot;
               s1_r0_in.desc_address = req_buffer_address;
               s1_r0_in.desc_length = req_buffer_length;
               s1_r0_in.desc_flags[DESC_FLAG_NEXT] = (left_nx != 9'd0);
               s1_r0_in.desc_flags[DESC_FLAG_WRITE] = req_device_writes;
               s1_r0_in.next_index = (left_nx != 9'd0) ? nxt : 8'd0;
               if (left_nx != 9'd0) begin
                  s1_r0_in.last = 1'b1;
                  s1_n_in = 2'd1;
               end else begin
                  avail_in = avail_ff + 16'd1;
                  s1_r1_in.kind = KIND_PUBLISH;
                  s1_r1_in.slot_index = avail_ff[7:0] & mask;
                  s1_r1_in.head_index = head_cur;
                  s1_r1_in.available_count = avail_ff + 16'd1;
                  s1_r1_in.tag = tag_cur;
                  s1_r1_in.notify_queue = queue_ff;
                  s1_r1_in.last = 1'b1;
                  s1_n_in = 2'd2;
               end
            end
         end
      end
   end

   // Hold control state and the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_log2_ff <= 4'd8;
         queue_ff <= '0;
         next_free_ff <= '0;
         free_ff <= 9'd1 << ring_log2_eff(4'd8);
         avail_ff <= '0;
         left_ff <= '0;
         head_ff <= '0;
         chain_tag_ff <= '0;
         dropping_ff <= 1'b0;
         s1_n_ff <= 2'd0;
         s1_cmp_ff <= 1'b0;
      end else begin
         ring_log2_ff <= ring_log2_in;
         queue_ff <= queue_in;
         next_free_ff <= next_free_in;
         free_ff <= free_in;
         avail_ff <= avail_in;
         left_ff <= left_in;
         head_ff <= head_in;
         chain_tag_ff <= chain_tag_in;
         dropping_ff <= dropping_in;
         s1_n_ff <= s1_n_in;
         s1_cmp_ff <= s1_cmp_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_r0_ff <= s1_r0_in;
      s1_r1_ff <= s1_r1_in;
   end

   // Tag memory: head tag written at chain start, read for used elements
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[mem_waddr] <= tag_cur;
      end
      tag_rd_ff <= tag_mem[req_used_id];
   end

   // Merge the looked-up tag into a completion
   always_comb begin
      push0 = s1_r0_ff;
      if (s1_cmp_ff) begin
         push0.tag = tag_rd_ff;
      end
   end

   drp_rsp_fifo u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .push_n (s1_n_ff),
      .push0  (push0),
      .push1  (s1_r1_ff),
      .pop    (rsp_tready),
      .head   (fifo_head),
      .count  (fifo_count)
   );

   assign rsp_tvalid = (fifo_count != '0);
   assign rsp_tuser = fifo_head.kind;
   assign rsp_tlast = fifo_head.last;
   assign rsp_tdata = {6'd0, fifo_head.notify_queue, fifo_head.tag,
                       fifo_head.available_count, fifo_head.head_index,
                       fifo_head.next_index, fifo_head.desc_flags,
                       fifo_head.desc_length, fifo_head.desc_address,
                       fifo_head.slot_index};

   // A pair of results is always a descriptor followed by its publish
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (s1_n_ff == 2'd2) |-> (s1_r0_ff.kind == KIND_DESC) && !s1_r0_ff.last &&
                            (s1_r1_ff.kind == KIND_PUBLISH) && s1_r1_ff.last)
      else $error("result pair out of order");

   // A used element yields exactly one completion in the next cycle
   a_used_one: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser && !csr_we) |=> (s1_n_ff == 2'd1) && s1_cmp_ff)
      else $error("used element did not yield one completion");

   // The free count never exceeds the ring size
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= ring_size)
      else $error("free count above ring size");

endmodule

### test/descriptor_ring_producer_test.sv
module descriptor_ring_producer_test;
   import drp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_TARGET = 950;

   // One input item, unpacked
   typedef struct {
      logic        action;
      logic [63:0] addr;
      logic [31:0] len;
      logic        dev_writes;
      logic [8:0]  seg_total;
      logic [15:0] ctag;
      logic [7:0]  used_id;
      logic [31:0] used_len;
   } req_item_type;

   // Tracks ring state and the results still owed by the block
   class ring_predictor_type;
      logic [3:0]  size_log2;
      logic [15:0] queue_num;
      logic [7:0]  next_slot;
      int unsigned free_left;
      logic [15:0] avail_next;
      int unsigned chain_rem;
      logic [7:0]  head_slot;
      bit          dropping;
      logic [15:0] tags [256];
      bit          tag_seen [256];
      logic [7:0]  tagged_ids [$];
      rsp_type     awaited [$];
      int mismatches, stray, shown;
      int n_desc, n_pub, n_comp, n_rej, n_drop;

      function new();
         size_log2 = 4'd8;
         queue_num = '0;
         next_slot = '0;
         free_left = entries();
         avail_next = '0;
         chain_rem = 0;
         head_slot = '0;
         dropping = 0;
         foreach (tag_seen[i]) tag_seen[i] = 0;
      endfunction

      function int unsigned entries();
         int unsigned lg;
         lg = (size_log2 > RingLog2Cap) ? RingLog2Cap : size_log2;
         return 1 << lg;
      endfunction

      function void write_reg(logic addr, logic [15:0] val);
         if (addr == REG_RING_SIZE_LOG2) begin
            size_log2 = val[3:0];
            free_left = entries();
            next_slot = '0;
            chain_rem = 0;
            dropping = 0;
         end else begin
            queue_num = val;
         end
      endfunction

      // Advance the ring for one accepted transfer; return 0 if it is dropped
      function bit note_request(req_item_type r);
         rsp_type e, p;
         int unsigned mask, total, slot, nxt;
         mask = entries() - 1;
         e = '0;
         if (r.action) begin
            e.kind = KIND_COMPLETE;
            e.slot_index = r.used_id;
            e.desc_length = r.used_len;
            e.tag = tags[r.used_id];
            e.last = 1'b1;
            awaited.push_back(e);
            n_comp++;
            return 1;
         end
         if (chain_rem == 0) begin
            total = (r.seg_total == 0) ? 1 : r.seg_total;
            if (free_left < total) begin
               chain_rem = total - 1;
               dropping = (chain_rem != 0);
               e.kind = KIND_REJECT;
               e.tag = r.ctag;
               e.last = 1'b1;
               awaited.push_back(e);
               n_rej++;
               return 1;
            end
            free_left -= total;
            head_slot = 8'(next_slot & mask);
            tags[head_slot] = r.ctag;
            if (!tag_seen[head_slot]) begin
               tag_seen[head_slot] = 1;
               tagged_ids.push_back(head_slot);
            end
            chain_rem = total;
            dropping = 0;
         end else if (dropping) begin
            chain_rem--;
            if (chain_rem == 0) dropping = 0;
            n_drop++;
            return 0;
         end
         // Write one descriptor
         slot = next_slot & mask;
         nxt = (slot + 1) & mask;
         chain_rem--;
         e.kind = KIND_DESC;
         e.slot_index = 8'(slot);
         e.desc_address = r.addr;
         e.desc_length = r.len;
         e.desc_flags[DESC_FLAG_NEXT] = (chain_rem != 0);
         e.desc_flags[DESC_FLAG_WRITE] = r.dev_writes;
         e.next_index = (chain_rem != 0) ? 8'(nxt) : 8'd0;
         e.last = (chain_rem != 0);
         next_slot = 8'(nxt);
         awaited.push_back(e);
         n_desc++;
         // Publish the head on the chain's final segment
         if (chain_rem == 0) begin
            p = '0;
            p.kind = KIND_PUBLISH;
            p.slot_index = 8'(avail_next & mask);
            avail_next = avail_next + 16'd1;
            p.head_index = head_slot;
            p.available_count = avail_next;
            p.tag = tags[head_slot];
            p.notify_queue = queue_num;
            p.last = 1'b1;
            awaited.push_back(p);
            n_pub++;
         end
         return 1;
      endfunction

      function string show(rsp_type r);
         return $sformatf({"kind=%0d slot=%0d addr=%h len=%h flags=%b next=%0d ",
                           "head=%0d avail=%0d tag=%h queue=%h last=%b"},
                          r.kind, r.slot_index, r.desc_address, r.desc_length,
                          r.desc_flags, r.next_index, r.head_index,
                          r.available_count, r.tag, r.notify_queue, r.last);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            stray++;
            if (shown < 10) begin
               shown++;
               $display("unexpected result: %s", show(got));
            end
            return;
         end
         want = awaited.pop_front();
         if (got !== want) begin
            mismatches++;
            if (shown < 10) begin
               shown++;
               $display("result mismatch\n   expected %s\n   actual   %s",
                        show(want), show(got));
            end
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function int failures();
         return mismatches + stray + awaited.size();
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tuser = 1'b0;
   logic [167:0]  req_tdata = '0;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [1:0]    rsp_tuser;
   logic [175:0]  rsp_tdata;
   logic          rsp_tlast;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic          csr_we = 1'b0;
   logic          csr_addr = 1'b0;
   logic [15:0]   csr_wdata = '0;

   ring_predictor_type model = new();
   int  counted_items = 0;
   int  sent_items = 0;
   int  settings = 0;
   int  cycle_count = 0;
   bit  burst_mode = 0;
   bit  hold_rsp = 0;
   bit  full_chain_done = 0;

   descriptor_ring_producer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // End the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("descriptor_ring_producer verification failed");
         $finish;
      end
   end

   function automatic int draw_gap();
      return burst_mode ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic req_item_type rand_item();
      req_item_type it;
      it.action = 1'b0;
      it.addr = {$urandom, $urandom};
      it.len = $urandom;
      it.dev_writes = 1'($urandom);
      it.seg_total = 9'($urandom);
      it.ctag = 16'($urandom);
      it.used_id = 8'($urandom);
      it.used_len = $urandom;
      return it;
   endfunction

   function automatic req_item_type mk_seg(logic [8:0] total, logic [15:0] ctag, logic dw);
      req_item_type it;
      it = rand_item();
      it.seg_total = total;
      it.ctag = ctag;
      it.dev_writes = dw;
      return it;
   endfunction

   function automatic req_item_type mk_used(logic [7:0] id, logic [31:0] ulen);
      req_item_type it;
      it = rand_item();
      it.action = 1'b1;
      it.used_id = id;
      it.used_len = ulen;
      return it;
   endfunction

   // Mostly well-formed chains, with used elements mixed in, zero totals that
   // count as one segment and some oversized chains that get rejected
   function automatic req_item_type next_random_item();
      req_item_type it;
      int unsigned pick, total;
      pick = $urandom_range(0, 99);
      if (model.tagged_ids.size() != 0 && pick < 12) begin
         return mk_used(model.tagged_ids[$urandom_range(0, model.tagged_ids.size() - 1)],
                        $urandom);
      end
      it = rand_item();
      if (model.chain_rem != 0) return it;
      if (!full_chain_done && model.free_left == 256) begin
         full_chain_done = 1;
         total = 256;
      end else if (pick < 60) begin
         total = $urandom_range(1, 4);
      end else if (pick < 70) begin
         total = 0;
      end else if (pick < 85) begin
         total = $urandom_range(1, model.free_left + 1);
      end else if (pick < 95) begin
         total = $urandom_range(1, 256);
      end else begin
         total = $urandom_range(257, 511);
      end
      it.seg_total = 9'(total);
      return it;
   endfunction

   // Offer one item after a random gap and hold it until the transfer
   task automatic send_item(input req_item_type it);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.action;
      req_tdata <= {6'b0, it.used_len, it.used_id, it.ctag, it.seg_total,
                    it.dev_writes, it.len, it.addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_items++;
      if (model.note_request(it)) counted_items++;
   endtask

   // Drain all results, then write both registers
   task automatic set_regs(input logic [3:0] lg, input logic [15:0] q);
      req_tvalid <= 1'b0;
      while (model.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= REG_RING_SIZE_LOG2;
      csr_wdata <= 16'(lg);
      @(posedge clock);
      model.write_reg(REG_RING_SIZE_LOG2, 16'(lg));
      csr_addr <= REG_QUEUE_NUMBER;
      csr_wdata <= q;
      @(posedge clock);
      model.write_reg(REG_QUEUE_NUMBER, q);
      csr_we <= 1'b0;
      settings++;
   endtask

   // Result side: random stalls, one long hold-off on request
   initial begin
      int gap;
      rsp_type got;
      @(negedge reset);
      forever begin
         gap = draw_gap();
         if (gap > 0 || hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
            while (hold_rsp) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got.kind = kind_type'(rsp_tuser);
         got.slot_index = rsp_tdata[7:0];
         got.desc_address = rsp_tdata[71:8];
         got.desc_length = rsp_tdata[103:72];
         got.desc_flags = rsp_tdata[105:104];
         got.next_index = rsp_tdata[113:106];
         got.head_index = rsp_tdata[121:114];
         got.available_count = rsp_tdata[137:122];
         got.tag = rsp_tdata[153:138];
         got.notify_queue = rsp_tdata[169:154];
         got.last = rsp_tlast;
         model.check_result(got);
      end
   end

   // Stall the result side long enough to back up the block
   initial begin
      wait (counted_items >= 420);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (300) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      req_item_type it;
      logic [3:0] lg;
      logic [15:0] q;
      int n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Four-entry ring: field extremes, zero total, used element inside a
      // chain, full ring rejects, dropped segments
      set_regs(4'd2, 16'hFFFF);
      it = mk_seg(9'd1, 16'hFFFF, 1'b1);
      it.addr = '1;
      it.len = '1;
      send_item(it);
      it = mk_seg(9'd0, 16'h0000, 1'b0);
      it.addr = '0;
      it.len = '0;
      send_item(it);
      send_item(mk_seg(9'd2, 16'h1234, 1'b1));
      send_item(mk_used(8'd0, 32'hFFFF_FFFF));
      send_item(mk_seg(9'h1FF, 16'hABCD, 1'b0));
      send_item(mk_seg(9'd1, 16'hA5A5, 1'b1));
      send_item(mk_seg(9'd3, 16'h5A5A, 1'b0));
      send_item(rand_item());
      send_item(rand_item());
      send_item(mk_used(8'd2, 32'd0));
      send_item(mk_used(8'd1, $urandom));
      send_item(mk_seg(9'h1FF, 16'hC3C3, 1'b1));

      // Single-entry ring; the write also closes the dropping chain
      set_regs(4'd0, 16'h0000);
      send_item(mk_seg(9'd1, 16'h1111, 1'b0));
      send_item(mk_seg(9'd1, 16'h2222, 1'b1));
      send_item(mk_used(8'd0, $urandom));

      // Close a chain that is still open by rewriting the ring size
      set_regs(4'd8, 16'h1234);
      send_item(mk_seg(9'd3, 16'h7777, 1'b1));
      send_item(rand_item());
      set_regs(4'd8, 16'h8001);
      send_item(mk_seg(9'd1, 16'h4242, 1'b0));

      // Random phases, each under its own ring size and queue number
      n = 0;
      while (sent_items < ITEM_TARGET) begin
         lg = (n == 0) ? 4'd8 : (n == 1) ? 4'd0 : 4'($urandom_range(0, 8));
         q = (n % 3 == 0) ? 16'h0000 : (n % 3 == 1) ? 16'hFFFF : 16'($urandom);
         burst_mode = (n % 4 == 3);
         set_regs(lg, q);
         repeat ((n == 0) ? 300 : $urandom_range(50, 120)) begin
            // Cut a long run of dropped segments short; the next write closes it
            if (sent_items >= ITEM_TARGET || (model.dropping && model.chain_rem > 8)) break;
            send_item(next_random_item());
         end
         n++;
      end

      req_tvalid <= 1'b0;
      while (model.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d items sent, %0d with results, under %0d register settings",
               sent_items, counted_items, settings);
      $display("%0d descriptors, %0d publishes, %0d completions, %0d rejects, %0d dropped",
               model.n_desc, model.n_pub, model.n_comp, model.n_rej, model.n_drop);
      if (model.failures() == 0) begin
         $display("descriptor_ring_producer verification clean");
      end else begin
         $display("%0d mismatches, %0d unexpected, %0d missing",
                  model.mismatches, model.stray, model.pending());
         $display("descriptor_ring_producer verification failed");
      end
      $finish;
   end

endmodule

### files.f
hdl/drp_pkg.sv
hdl/drp_rsp_fifo.sv
hdl/descriptor_ring_producer.sv
test/descriptor_ring_producer_test.sv
